[hw/rtl/rdc_pkg.sv]
package rdc_pkg;

    localparam int RADIX_W = 5;
    localparam int DIGIT_W = 4;
    localparam int CHAR_W  = 7;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd16;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_A    = 7'h41;
    localparam logic [DIGIT_W-1:0] DEC_TEN  = 4'd10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } rdc_state_t;

    // broadcast controls for every cell of the row
    typedef struct packed {
        logic clear;
        logic shift;
    } cell_ctrl_t;

    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DEC_TEN)
            c = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, d};
        else
            c = CHAR_A + {{(CHAR_W-DIGIT_W){1'b0}}, d - DEC_TEN};
        return c;
    endfunction

endpackage

[hw/rtl/radix_digit_converter.sv]
// channel | direction | handshake             | payload
// --------+-----------+-----------------------+-------------------------------
// in      | input     | in_valid / in_ready   | value [WORD_BITS]
// out     | output    | out_valid / out_ready | digit [4], digit_char [7], last
// cfg     | input     | cfg_valid / cfg_ready | radix [5]
//
// an item is accepted, then converted while the bits walk up the digit cells, then
// scanned out of the top cell, most significant digit first;
// each scan cycle that shows a digit waits for the output register to be free
// a new item is taken once the last digit sits in the output register
// reset clears control state and sets the radix to 16; no clearing pass
// cfg_ready is always high; the user must write the radix only while idle (not enforced)
module radix_digit_converter
    import rdc_pkg::*;
#(
    parameter int WORD_BITS  = 32,
    parameter int MAX_DIGITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [WORD_BITS-1:0] value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [DIGIT_W-1:0]   digit,
    output logic [CHAR_W-1:0]    digit_char,
    output logic                 last,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [RADIX_W-1:0]   radix
);

    localparam int CONV_CYCLES = WORD_BITS + MAX_DIGITS - 1;
    localparam int CNT_W       = $clog2(CONV_CYCLES + 1);
    localparam int POS_W       = $clog2(MAX_DIGITS);

    rdc_state_t           state_reg;
    rdc_state_t           state_next;
    logic [RADIX_W-1:0]   radix_reg;
    logic [RADIX_W-1:0]   radix_eff;
    logic [WORD_BITS-1:0] word_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [POS_W-1:0]     pos_reg;
    logic                 started_reg;
    logic                 out_valid_reg;
    logic [DIGIT_W-1:0]   digit_reg;
    logic [CHAR_W-1:0]    char_reg;
    logic                 last_reg;

    logic                 accept;
    logic                 feed_valid;
    logic                 conv_done;
    logic                 last_pos;
    logic                 emit_now;
    logic                 out_free;
    logic                 advance;
    logic                 load;
    cell_ctrl_t           ctrl;
    logic [DIGIT_W-1:0]   top_digit;
    logic                 top_carry;

    // radix clamp: below two acts as base 2, above sixteen as base 16
    always_comb
    begin
        if (radix_reg < RADIX_MIN)
            radix_eff = RADIX_MIN;
        else if (radix_reg > RADIX_MAX)
            radix_eff = RADIX_MAX;
        else
            radix_eff = radix_reg;
    end

    assign conv_done = (cnt_reg == CNT_W'(CONV_CYCLES - 1));
    assign last_pos  = (pos_reg == POS_W'(MAX_DIGITS - 1));
    // leading zeros are skipped, but the least significant digit always shows;
    // a word wider than the cells keeps every cell digit, zero or not
    assign emit_now  = started_reg || top_carry || (top_digit != '0) || last_pos;
    assign out_free  = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_CONV;
            end
            ST_CONV:
            begin
                if (conv_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (advance && last_pos)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready   = 1'b0;
        feed_valid = 1'b0;
        advance    = 1'b0;
        load       = 1'b0;
        ctrl.clear = 1'b0;
        ctrl.shift = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                ctrl.clear = in_valid;
            end
            ST_CONV:
            begin
                feed_valid = (cnt_reg < CNT_W'(WORD_BITS));
            end
            ST_EMIT:
            begin
                advance    = !emit_now || out_free;
                load       = advance && emit_now;
                ctrl.shift = advance;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            radix_reg     <= RADIX_RESET;
            cnt_reg       <= '0;
            pos_reg       <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
                radix_reg <= radix;
            if (accept)
            begin
                cnt_reg     <= '0;
                pos_reg     <= '0;
                started_reg <= 1'b0;
            end
            else if (state_reg == ST_CONV)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (top_carry)
                    started_reg <= 1'b1;
            end
            else if (state_reg == ST_EMIT)
            begin
                if (advance)
                    pos_reg <= pos_reg + POS_W'(1);
                if (emit_now)
                    started_reg <= 1'b1;
            end
            if (load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload: input word shifts out msb first, output digit register
    always_ff @(posedge clk)
    begin
        if (accept)
            word_reg <= value;
        else if (feed_valid)
            word_reg <= {word_reg[WORD_BITS-2:0], 1'b0};
        if (load)
        begin
            digit_reg <= top_digit;
            char_reg  <= digit_to_char(top_digit);
            last_reg  <= last_pos;
        end
    end

    rdc_chain #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .radix_eff  (radix_eff),
        .feed_valid (feed_valid),
        .feed_bit   (word_reg[WORD_BITS-1]),
        .top_digit  (top_digit),
        .top_carry  (top_carry)
    );

    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign digit      = digit_reg;
    assign digit_char = char_reg;
    assign last       = last_reg;

endmodule

[hw/rtl/rdc_cell.sv]
module rdc_cell
    import rdc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cell_ctrl_t         ctrl,
    input  logic [RADIX_W-1:0] radix_eff,
    input  logic               step_in,
    input  logic               carry_in,
    input  logic [DIGIT_W-1:0] digit_in,
    output logic               step_out,
    output logic               carry_out,
    output logic [DIGIT_W-1:0] digit
);

    logic [DIGIT_W-1:0] digit_reg;
    logic [DIGIT_W-1:0] digit_next;
    logic               step_reg;
    logic               carry_reg;
    logic [RADIX_W-1:0] sum;
    logic               wrap;

    // doubled digit plus incoming bit, one compare and subtract
    always_comb
    begin
        sum  = {digit_reg, carry_in};
        wrap = (sum >= radix_eff);
        if (ctrl.clear)
            digit_next = '0;
        else if (ctrl.shift)
            digit_next = digit_in;
        else if (step_in)
            digit_next = wrap ? DIGIT_W'(sum - radix_eff) : DIGIT_W'(sum);
        else
            digit_next = digit_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= 1'b0;
            carry_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_in & ~ctrl.clear;
            carry_reg <= step_in & wrap;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

    assign step_out  = step_reg;
    assign carry_out = carry_reg;
    assign digit     = digit_reg;

endmodule

[hw/rtl/rdc_chain.sv]
module rdc_chain
    import rdc_pkg::*;
#(
    parameter int MAX_DIGITS = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cell_ctrl_t         ctrl,
    input  logic [RADIX_W-1:0] radix_eff,
    input  logic               feed_valid,
    input  logic               feed_bit,
    output logic [DIGIT_W-1:0] top_digit,
    output logic               top_carry
);

    logic [MAX_DIGITS:0]  step_link;
    logic [MAX_DIGITS:0]  carry_link;
    logic [DIGIT_W-1:0]   digit_link [MAX_DIGITS+1];

    assign step_link[0]  = feed_valid;
    assign carry_link[0] = feed_bit;
    assign digit_link[0] = '0;

    // cell 0 holds the least significant digit; carries ripple up one cell a cycle
    for (genvar i = 0; i < MAX_DIGITS; i++)
    begin : g_cell
        rdc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .radix_eff (radix_eff),
            .step_in   (step_link[i]),
            .carry_in  (carry_link[i]),
            .digit_in  (digit_link[i]),
            .step_out  (step_link[i+1]),
            .carry_out (carry_link[i+1]),
            .digit     (digit_link[i+1])
        );
    end

    assign top_digit = digit_link[MAX_DIGITS];
    // carry out of the top cell: the word has more digits than cells
    assign top_carry = carry_link[MAX_DIGITS];

endmodule

[verif/rdc_digit_checker.sv]
`timescale 1ns / 100ps

module rdc_digit_checker
    import rdc_pkg::*;
#(
    parameter int WORD_BITS  = 32,
    parameter int MAX_DIGITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [WORD_BITS-1:0] value,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [DIGIT_W-1:0]   digit,
    input  logic [CHAR_W-1:0]    digit_char,
    input  logic                 last,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [RADIX_W-1:0]   radix,
    output int                   fail_count,
    output int                   words_in,
    output int                   digits_left
);

    typedef struct packed {
        logic [DIGIT_W-1:0] dval;
        logic [CHAR_W-1:0]  chr;
        logic               fin;
    } digit_rec_t;

    digit_rec_t         expected_digits [$];
    logic [RADIX_W-1:0] cur_radix = RADIX_RESET;
    int                 err_cnt = 0;
    int                 word_cnt = 0;

    initial begin
        fail_count  = 0;
        words_in    = 0;
        digits_left = 0;
    end

    function automatic logic [CHAR_W-1:0] ascii_of(input logic [DIGIT_W-1:0] d);
        if (d < DEC_TEN)
            return CHAR_ZERO + CHAR_W'(d);
        return CHAR_A + CHAR_W'(d - DEC_TEN);
    endfunction

    // queues the digits of one word, most significant first
    function automatic void split_word(input logic [WORD_BITS-1:0] w);
        logic [RADIX_W-1:0]   base;
        logic [WORD_BITS-1:0] rest;
        logic [DIGIT_W-1:0]   lsd_first [MAX_DIGITS];
        int                   n;
        digit_rec_t           rec;
        if (cur_radix < RADIX_MIN)
            base = RADIX_MIN;
        else if (cur_radix > RADIX_MAX)
            base = RADIX_MAX;
        else
            base = cur_radix;
        rest = w;
        n = 0;
        do
        begin
            lsd_first[n] = DIGIT_W'(rest % WORD_BITS'(base));
            rest = rest / WORD_BITS'(base);
            n++;
        end
        while (rest != '0 && n < MAX_DIGITS);
        for (int k = n - 1; k >= 0; k--)
        begin
            rec.dval = lsd_first[k];
            rec.chr  = ascii_of(lsd_first[k]);
            rec.fin  = (k == 0);
            expected_digits.push_back(rec);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        digit_rec_t exp_rec;
        if (!rst_n)
        begin
            expected_digits.delete();
            cur_radix = RADIX_RESET;
            err_cnt   = 0;
            word_cnt  = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                cur_radix = radix;
            // results leave before a word accepted on the same edge is queued
            if (out_valid && out_ready)
            begin
                if (expected_digits.size() == 0)
                begin
                    $error("digit transfer with nothing expected: digit %0d digit_char %0d last %0b",
                           digit, digit_char, last);
                    err_cnt++;
                end
                else
                begin
                    exp_rec = expected_digits.pop_front();
                    if (digit !== exp_rec.dval)
                    begin
                        $error("digit: expected %0d, actual %0d", exp_rec.dval, digit);
                        err_cnt++;
                    end
                    if (digit_char !== exp_rec.chr)
                    begin
                        $error("digit_char: expected %0d, actual %0d", exp_rec.chr, digit_char);
                        err_cnt++;
                    end
                    if (last !== exp_rec.fin)
                    begin
                        $error("last: expected %0b, actual %0b", exp_rec.fin, last);
                        err_cnt++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                split_word(value);
                word_cnt++;
            end
        end
        fail_count  <= err_cnt;
        words_in    <= word_cnt;
        digits_left <= expected_digits.size();
    end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import rdc_pkg::*;

    localparam int WORD_BITS      = 32;
    localparam int MAX_DIGITS     = 32;
    localparam int TAIL_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SEGMENTS       = 12;
    localparam int WORDS_PER_SEG  = 17;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [WORD_BITS-1:0] value;
    logic                 out_valid;
    logic                 out_ready;
    logic [DIGIT_W-1:0]   digit;
    logic [CHAR_W-1:0]    digit_char;
    logic                 last;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [RADIX_W-1:0]   radix;

    int fail_count;
    int words_in;
    int digits_left;

    // idle percentages for the word sender and the digit receiver
    int send_idle_pct = 32;
    int recv_idle_pct = 75;
    // words handed over so far, counted at our own handshake
    int n_sent = 0;
    int idle_cycles = 0;

    // radix corners, written on every other random segment
    logic [RADIX_W-1:0] corner_radix [6] = '{5'd2, 5'd16, 5'd0, 5'd31, 5'd10, 5'd1};

    always #5 clk = ~clk;

    radix_digit_converter #(
        .WORD_BITS  (WORD_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .digit      (digit),
        .digit_char (digit_char),
        .last       (last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .radix      (radix)
    );

    // predicts the digit stream and compares every output transfer
    rdc_digit_checker #(
        .WORD_BITS  (WORD_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .digit       (digit),
        .digit_char  (digit_char),
        .last        (last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .radix       (radix),
        .fail_count  (fail_count),
        .words_in    (words_in),
        .digits_left (digits_left)
    );

    // receiver back-pressure, one fresh decision per cycle
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // watchdog: a long stretch with no transfer on any channel means a hang
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // offers one word; valid stays up when the next word follows without a gap,
    // so this task lowers it only on a cycle the sender chooses to idle
    task automatic send_word(input logic [WORD_BITS-1:0] w);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= w;
        do
            @(posedge clk);
        while (!in_ready);
        n_sent++;
    endtask

    // waits until every accepted word has been fully checked, block is idle then
    task automatic drain_block();
        in_valid <= 1'b0;
        while (words_in != n_sent || digits_left != 0)
            @(posedge clk);
    endtask

    // radix write, only ever issued after drain_block
    task automatic write_radix(input logic [RADIX_W-1:0] r);
        cfg_valid <= 1'b1;
        radix     <= r;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // mix of short words, wide words, negative patterns and near all-ones
    function automatic logic [WORD_BITS-1:0] random_word();
        logic [WORD_BITS-1:0] w;
        case ($urandom_range(0, 5))
            0: w = $urandom_range(0, 255);
            1: w = $urandom() >> $urandom_range(1, 31);
            2: w = 32'h8000_0000 | $urandom();
            3: w = 32'hFFFF_FFFF - $urandom_range(0, 15);
            default: w = $urandom();
        endcase
        return w;
    endfunction

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        value     = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        radix     = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed words, first at the reset radix of sixteen
        send_word(32'h0000_0000);
        send_word(32'h0000_0001);
        send_word(32'h0000_000F);
        send_word(32'h0000_0010);
        send_word(32'hFFFF_FFFF);
        send_word(32'h8000_0000);
        send_word(32'h0123_4567);
        send_word(32'h89AB_CDEF);
        // negative word whose lowest digit is zero
        send_word(32'hFFFF_FFF0);

        // base two: all ones gives the longest run of thirty-two digits
        drain_block();
        write_radix(5'd2);
        send_word(32'hFFFF_FFFF);
        send_word(32'h8000_0000);
        send_word(32'h0000_0002);

        // decimal, negative word ending in a zero digit
        drain_block();
        write_radix(5'd10);
        send_word(32'hFFFF_FFFF);
        send_word(32'd10);
        send_word(32'd9);
        send_word(32'hFFFF_FFFA);

        // radix below two falls back to base two
        drain_block();
        write_radix(5'd0);
        send_word(32'd5);
        drain_block();
        write_radix(5'd1);
        send_word(32'd6);

        // radix above sixteen falls back to base sixteen
        drain_block();
        write_radix(5'd17);
        send_word(32'd255);
        drain_block();
        write_radix(5'd31);
        send_word(32'hFFFF_FFFF);

        // odd base with the widest word
        drain_block();
        write_radix(5'd3);
        send_word(32'hFFFF_FFFF);

        // random segments, each under its own radix; idling swaps then stops
        for (int s = 0; s < SEGMENTS; s++)
        begin
            drain_block();
            if (s == SEGMENTS / 3)
            begin
                send_idle_pct = 75;
                recv_idle_pct = 32;
            end
            else if (s == 2 * SEGMENTS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (s % 2 == 0)
                write_radix(corner_radix[s / 2]);
            else
                write_radix(RADIX_W'($urandom_range(2, 16)));
            for (int i = 0; i < WORDS_PER_SEG; i++)
                send_word(random_word());
        end

        // all words in; let the last digits come out, then watch for extras
        drain_block();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0 && digits_left == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/rdc_pkg.sv
hw/rtl/rdc_cell.sv
hw/rtl/rdc_chain.sv
hw/rtl/radix_digit_converter.sv
verif/rdc_digit_checker.sv
verif/tb_top.sv
